// ----- hdl/jsu_pkg.sv -----
// Shared types, codes and helper functions of the JSON string unescape unit.
package jsu_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int JOB_BYTES = 8;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
    localparam logic [3:0] ERR_UNTERM     = 4'd2;
    localparam logic [3:0] ERR_CONTROL    = 4'd3;
    localparam logic [3:0] ERR_BAD_UTF8   = 4'd4;
    localparam logic [3:0] ERR_TRUNC_UTF8 = 4'd5;
    localparam logic [3:0] ERR_ESC_CUT    = 4'd6;
    localparam logic [3:0] ERR_SHORT_U    = 4'd7;
    localparam logic [3:0] ERR_NON_HEX    = 4'd8;
    localparam logic [3:0] ERR_UNKNOWN    = 4'd9;
    localparam logic [3:0] ERR_BUDGET     = 4'd10;

    localparam logic [20:0] CODE_REPLACEMENT = 21'h00FFFD;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } piece_t;

    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [3:0]                nbytes;
        logic                      term_en;
        logic                      term_done;
        logic [3:0]                term_err;
        logic [15:0]               base;
    } job_t;

    function automatic piece_t encode_utf8(input logic [20:0] c);
        piece_t p;
        p = '0;
        if (c < 21'h80) begin
            p.bytes[0] = c[7:0];
            p.n = 3'd1;
        end
        else if (c < 21'h800) begin
            p.bytes[0] = {3'b110, c[10:6]};
            p.bytes[1] = {2'b10, c[5:0]};
            p.n = 3'd2;
        end
        else if (c < 21'h10000) begin
            p.bytes[0] = {4'b1110, c[15:12]};
            p.bytes[1] = {2'b10, c[11:6]};
            p.bytes[2] = {2'b10, c[5:0]};
            p.n = 3'd3;
        end
        else begin
            p.bytes[0] = {5'b11110, c[20:18]};
            p.bytes[1] = {2'b10, c[17:12]};
            p.bytes[2] = {2'b10, c[11:6]};
            p.bytes[3] = {2'b10, c[5:0]};
            p.n = 3'd4;
        end
        return p;
    endfunction

    // Returns the digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= "0" && b <= "9") begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= "a" && b <= "f") begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= "A" && b <= "F") begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ----- hdl/jsu_front.sv -----
// Front part: accepts input bytes, runs the string decoder and builds at most one job per byte.
module jsu_front #(
    parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [15:0]    cfg_data,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           end_of_data,
    output logic           job_push,
    output jsu_pkg::job_t  job
);
    import jsu_pkg::*;

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_BODY = 3'd1;
    localparam logic [2:0] M_ESC  = 3'd2;
    localparam logic [2:0] M_HEX  = 3'd3;
    localparam logic [2:0] M_UTF  = 3'd4;
    localparam logic [2:0] M_PEND = 3'd5;
    localparam logic [2:0] M_PESC = 3'd6;
    localparam logic [2:0] M_PHEX = 3'd7;

    localparam int CW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;
    localparam logic [CW-1:0] CAP = CW'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [15:0]            max_length_reg;
    logic [2:0]             mode_reg, mode_next;
    logic [1:0]             cont_reg, cont_next;
    logic [1:0]             lead_reg, lead_next;
    logic [20:0]            acc_reg, acc_next;
    logic [2:0]             hex_reg, hex_next;
    logic [9:0]             pend_reg, pend_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [7:0]             held_reg [0:2];
    logic [7:0]             held_next [0:2];

    logic [CW-1:0] limit;
    logic [4:0]    hv;
    logic          is_quote, is_bs;
    logic          do_body, do_esc, do_fin;
    logic [15:0]   fin_c, hex_acc;
    logic          pre_en, mp_en, ep_en, mt_en, mt_done, e_en, fail10, any_term;
    logic [3:0]    mt_err, e_err;
    piece_t        mp;
    piece_t        pieces [0:2];
    logic          pen [0:2];
    logic [CW-1:0] cnt;
    logic [3:0]    pos;
    logic [LENGTH_BITS-1:0] base_len;
    logic [1:0]    uidx;
    logic [20:0]   uacc;
    logic [20:0]   umin;

    assign limit = ({{(CW-16){1'b0}}, max_length_reg} < CAP)
                 ? {{(CW-16){1'b0}}, max_length_reg} : CAP;
    assign hv = hex_value(in_byte);
    assign is_quote = (in_byte == 8'h22);
    assign is_bs = (in_byte == 8'h5C);
    assign hex_acc = {acc_reg[11:0], hv[3:0]};

    always_comb
    begin
        mode_next = mode_reg;
        cont_next = cont_reg;
        lead_next = lead_reg;
        acc_next = acc_reg;
        hex_next = hex_reg;
        pend_next = pend_reg;
        held_next = held_reg;
        base_len = len_reg;
        do_body = 1'b0;
        do_esc = 1'b0;
        do_fin = 1'b0;
        fin_c = hex_acc;
        pre_en = 1'b0;
        mp_en = 1'b0;
        mp = '0;
        mt_en = 1'b0;
        mt_done = 1'b0;
        mt_err = ERR_NONE;
        uidx = '0;
        uacc = '0;
        umin = '0;

        unique case (mode_reg)
            M_IDLE:
            begin
                if (is_quote) begin
                    mode_next = M_BODY;
                    cont_next = '0;
                    lead_next = '0;
                    acc_next = '0;
                    hex_next = '0;
                    pend_next = '0;
                    base_len = '0;
                end
                else begin
                    mt_en = 1'b1;
                    mt_err = ERR_NO_QUOTE;
                end
            end
            M_BODY: do_body = 1'b1;
            M_ESC: do_esc = 1'b1;
            M_HEX:
            begin
                if (!hv[4]) begin
                    mt_en = 1'b1;
                    mt_err = ERR_NON_HEX;
                end
                else begin
                    acc_next = {5'd0, hex_acc};
                    hex_next = hex_reg + 3'd1;
                    if (hex_reg + 3'd1 >= 3'd4) begin
                        do_fin = 1'b1;
                    end
                end
            end
            M_UTF:
            begin
                if (in_byte[7:6] != 2'b10) begin
                    mt_en = 1'b1;
                    mt_err = ERR_BAD_UTF8;
                end
                else begin
                    uidx = lead_reg + 2'd1 - cont_reg;
                    if (uidx == 2'd1 || uidx == 2'd2) begin
                        held_next[uidx] = in_byte;
                    end
                    uacc = {acc_reg[14:0], in_byte[5:0]};
                    acc_next = uacc;
                    cont_next = cont_reg - 2'd1;
                    if (cont_reg == 2'd1) begin
                        umin = (lead_reg == 2'd1) ? 21'h80
                             : ((lead_reg == 2'd2) ? 21'h800 : 21'h10000);
                        if (uacc < umin || uacc > 21'h10FFFF
                            || (uacc >= 21'hD800 && uacc <= 21'hDFFF)) begin
                            mt_en = 1'b1;
                            mt_err = ERR_BAD_UTF8;
                        end
                        else begin
                            mp_en = 1'b1;
                            mp.bytes[0] = held_next[0];
                            mp.bytes[1] = held_next[1];
                            mp.bytes[2] = held_next[2];
                            mp.bytes[lead_reg] = in_byte;
                            mp.n = {1'b0, lead_reg} + 3'd1;
                            mode_next = M_BODY;
                            lead_next = '0;
                        end
                    end
                end
            end
            M_PEND:
            begin
                if (is_bs) begin
                    mode_next = M_PESC;
                end
                else begin
                    mode_next = M_BODY;
                    pre_en = 1'b1;
                    do_body = 1'b1;
                end
            end
            M_PESC:
            begin
                if (in_byte == 8'h75) begin
                    mode_next = M_PHEX;
                    acc_next = '0;
                    hex_next = '0;
                end
                else begin
                    mode_next = M_BODY;
                    pre_en = 1'b1;
                    do_esc = 1'b1;
                end
            end
            M_PHEX:
            begin
                if (!hv[4]) begin
                    pre_en = 1'b1;
                    mt_en = 1'b1;
                    mt_err = ERR_NON_HEX;
                end
                else begin
                    acc_next = {5'd0, hex_acc};
                    hex_next = hex_reg + 3'd1;
                    if (hex_reg + 3'd1 >= 3'd4) begin
                        mode_next = M_BODY;
                        if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                            pend_next = '0;
                            mp_en = 1'b1;
                            mp = encode_utf8(21'h10000 + {1'b0, pend_reg, hex_acc[9:0]});
                        end
                        else begin
                            pre_en = 1'b1;
                            do_fin = 1'b1;
                        end
                    end
                end
            end
            default: mode_next = M_IDLE;
        endcase

        if (do_body) begin
            priority if (is_quote) begin
                mt_en = 1'b1;
                mt_done = 1'b1;
            end
            else if (in_byte < 8'h20) begin
                mt_en = 1'b1;
                mt_err = ERR_CONTROL;
            end
            else if (is_bs) begin
                mode_next = M_ESC;
            end
            else if (in_byte < 8'h80) begin
                mp_en = 1'b1;
                mp.bytes[0] = in_byte;
                mp.n = 3'd1;
            end
            else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
                held_next[0] = in_byte;
                lead_next = 2'd1;
                cont_next = 2'd1;
                acc_next = {16'd0, in_byte[4:0]};
                mode_next = M_UTF;
            end
            else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
                held_next[0] = in_byte;
                lead_next = 2'd2;
                cont_next = 2'd2;
                acc_next = {17'd0, in_byte[3:0]};
                mode_next = M_UTF;
            end
            else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
                held_next[0] = in_byte;
                lead_next = 2'd3;
                cont_next = 2'd3;
                acc_next = {18'd0, in_byte[2:0]};
                mode_next = M_UTF;
            end
            else begin
                mt_en = 1'b1;
                mt_err = ERR_BAD_UTF8;
            end
        end

        if (do_esc) begin
            mode_next = M_BODY;
            mp.n = 3'd1;
            unique case (in_byte)
                8'h22, 8'h5C, 8'h2F: begin mp_en = 1'b1; mp.bytes[0] = in_byte; end
                8'h62: begin mp_en = 1'b1; mp.bytes[0] = 8'h08; end
                8'h66: begin mp_en = 1'b1; mp.bytes[0] = 8'h0C; end
                8'h6E: begin mp_en = 1'b1; mp.bytes[0] = 8'h0A; end
                8'h72: begin mp_en = 1'b1; mp.bytes[0] = 8'h0D; end
                8'h74: begin mp_en = 1'b1; mp.bytes[0] = 8'h09; end
                8'h75:
                begin
                    mode_next = M_HEX;
                    acc_next = '0;
                    hex_next = '0;
                end
                default:
                begin
                    mt_en = 1'b1;
                    mt_err = ERR_UNKNOWN;
                end
            endcase
        end

        if (do_fin) begin
            if (fin_c >= 16'hD800 && fin_c <= 16'hDBFF) begin
                pend_next = fin_c[9:0];
                mode_next = M_PEND;
            end
            else begin
                mode_next = M_BODY;
                mp_en = 1'b1;
                if (fin_c >= 16'hDC00 && fin_c <= 16'hDFFF) begin
                    mp = encode_utf8(CODE_REPLACEMENT);
                end
                else begin
                    mp = encode_utf8({5'd0, fin_c});
                end
            end
        end
    end

    always_comb
    begin
        ep_en = 1'b0;
        e_en = 1'b0;
        e_err = ERR_NONE;
        if (end_of_data && !mt_en && mode_next != M_IDLE) begin
            e_en = 1'b1;
            unique case (mode_next)
                M_ESC: e_err = ERR_ESC_CUT;
                M_HEX: e_err = ERR_SHORT_U;
                M_UTF: e_err = ERR_TRUNC_UTF8;
                M_PEND: begin ep_en = 1'b1; e_err = ERR_UNTERM; end
                M_PESC: begin ep_en = 1'b1; e_err = ERR_ESC_CUT; end
                M_PHEX: begin ep_en = 1'b1; e_err = ERR_SHORT_U; end
                default: e_err = ERR_UNTERM;
            endcase
        end
    end

    always_comb
    begin
        pieces[0] = encode_utf8(CODE_REPLACEMENT);
        pieces[1] = mp;
        pieces[2] = encode_utf8(CODE_REPLACEMENT);
        pen[0] = pre_en;
        pen[1] = mp_en;
        pen[2] = ep_en;
        cnt = CW'(base_len);
        pos = '0;
        fail10 = 1'b0;
        job = '0;
        for (int k = 0; k < 3; k++) begin
            if (pen[k] && !fail10) begin
                if (cnt + CW'(pieces[k].n) > limit) begin
                    fail10 = 1'b1;
                end
                else begin
                    for (int i = 0; i < 4; i++) begin
                        if (3'(i) < pieces[k].n) begin
                            job.bytes[3'(pos + 4'(i))] = pieces[k].bytes[i];
                        end
                    end
                    pos = pos + {1'b0, pieces[k].n};
                    cnt = cnt + CW'(pieces[k].n);
                end
            end
        end
        job.nbytes = pos;
        job.base = 16'(base_len);
        any_term = fail10 || mt_en || e_en;
        job.term_en = any_term;
        job.term_done = !fail10 && mt_en && mt_done;
        job.term_err = fail10 ? ERR_BUDGET : (mt_en ? mt_err : e_err);
        len_next = LENGTH_BITS'(cnt);
        job_push = accept && (any_term || pos != 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_length_reg <= 16'hFFFF;
            mode_reg <= M_IDLE;
            cont_reg <= '0;
            lead_reg <= '0;
            acc_reg <= '0;
            hex_reg <= '0;
            pend_reg <= '0;
            len_reg <= '0;
        end
        else begin
            if (cfg_write) begin
                max_length_reg <= cfg_data;
            end
            if (accept) begin
                len_reg <= len_next;
                if (any_term) begin
                    mode_reg <= M_IDLE;
                    cont_reg <= '0;
                    lead_reg <= '0;
                    acc_reg <= '0;
                    hex_reg <= '0;
                    pend_reg <= '0;
                end
                else begin
                    mode_reg <= mode_next;
                    cont_reg <= cont_next;
                    lead_reg <= lead_next;
                    acc_reg <= acc_next;
                    hex_reg <= hex_next;
                    pend_reg <= pend_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// ----- hdl/jsu_queue.sv -----
// Short job queue between the front and back parts.
module jsu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  jsu_pkg::job_t  push_job,
    input  logic           pop,
    output logic           head_valid,
    output jsu_pkg::job_t  head_job,
    output logic           full
);
    import jsu_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t          mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign head_job = mem[rd_reg];

    always_comb
    begin
        wr_next = push ? wr_reg + PW'(1) : wr_reg;
        rd_next = pop ? rd_reg + PW'(1) : rd_reg;
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/jsu_back.sv -----
// Back part: expands each job into result words and drives the output register.
module jsu_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  jsu_pkg::job_t  head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic           byte_valid,
    output logic           last,
    output logic           done_res,
    output logic [3:0]     error_code,
    output logic [15:0]    byte_count
);
    import jsu_pkg::*;

    logic        ov_reg;
    logic [2:0]  idx_reg, idx_next;
    logic        load, is_byte, is_last;
    logic [3:0]  total;
    logic [7:0]  byte_reg, byte_next;
    logic        bv_reg, last_reg, done_reg;
    logic [3:0]  err_reg, err_next;
    logic [15:0] cnt_reg, cnt_next;

    assign load = head_valid && (!ov_reg || !out_stall);
    assign total = head_job.nbytes + {3'd0, head_job.term_en};
    assign is_byte = ({1'b0, idx_reg} < head_job.nbytes);
    assign is_last = ({1'b0, idx_reg} + 4'd1 == total);
    assign pop = load && is_last;

    always_comb
    begin
        idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
        byte_next = is_byte ? head_job.bytes[idx_reg] : 8'd0;
        err_next = is_byte ? ERR_NONE : head_job.term_err;
        cnt_next = is_byte ? head_job.base + 16'(idx_reg) + 16'd1
                           : head_job.base + 16'(head_job.nbytes);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ov_reg <= 1'b0;
            idx_reg <= '0;
        end
        else begin
            if (load) begin
                ov_reg <= 1'b1;
                idx_reg <= idx_next;
            end
            else if (!out_stall) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg <= byte_next;
            bv_reg <= is_byte;
            last_reg <= is_last;
            done_reg <= !is_byte && head_job.term_done;
            err_reg <= err_next;
            cnt_reg <= cnt_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte = byte_reg;
    assign byte_valid = bv_reg;
    assign last = last_reg;
    assign done_res = done_reg;
    assign error_code = err_reg;
    assign byte_count = cnt_reg;

endmodule

// ----- hdl/json_string_unescape_utf8_unit.sv -----
// Top level of the JSON string unescape unit with UTF-8 checking.
//
// Input words carry one string byte and an end-of-data flag; the first byte of a
// string must be the opening quote. Each output word carries one decoded UTF-8
// byte, or a final word with done or an error code, plus the running byte count.
// The last word caused by one input byte has last set.
// Both channels use valid and stall. The front accepts one byte per cycle and
// turns it into a job of up to seven output words; a four-entry job queue sits
// between the front and the back, which sends one output word per cycle unless stalled.
// Sustained input rate is one byte per cycle while the output keeps up; bytes
// that cause several output words are absorbed by the queue, and input stalls
// only when the queue is full.
// When the receiver stalls, the output word holds and the queue fills.
// Reset empties the queue and the output register, sets the limit to 65535 and
// leaves the decoder waiting for an opening quote. The user must write the
// max_length register via cfg_write and cfg_data only while idle (not enforced).
module json_string_unescape_utf8_unit #(
    parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        last,
    output logic        done_res,
    output logic [3:0]  error_code,
    output logic [15:0] byte_count
);
    import jsu_pkg::*;

    logic accept, push, pop, head_valid, full;
    job_t new_job, head_job;

    assign in_stall = full;
    assign accept = in_valid && !full;

    jsu_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .accept(accept),
        .in_byte(in_byte),
        .end_of_data(end_of_data),
        .job_push(push),
        .job(new_job)
    );

    jsu_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_job(new_job),
        .pop(pop),
        .head_valid(head_valid),
        .head_job(head_job),
        .full(full)
    );

    jsu_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head_valid(head_valid),
        .head_job(head_job),
        .pop(pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .byte_valid(byte_valid),
        .last(last),
        .done_res(done_res),
        .error_code(error_code),
        .byte_count(byte_count)
    );

endmodule
